>>> hw/rtl/assert_macros.svh
// Assertion helper macros for the servo tracker RTL.
// Clocked, reset-qualified concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define DTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent implies consequent at the next clock.
`define DTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/dts_pkg.sv
// Package for the deadband tracking servo scan block.
// Word types, command and register codes, fixed-point constants, helpers.
`timescale 1ns / 1ps
`default_nettype none

package dts_pkg;

  localparam int COUNT_WIDTH    = 12;
  localparam int POSE_FRAC_BITS = 8;

  localparam int POSE_W   = 8 + POSE_FRAC_BITS;
  localparam int EXT_W    = 28;
  localparam int CMP_W    = (COUNT_WIDTH > 12) ? COUNT_WIDTH : 12;

  localparam int MUL_A_W  = 16;
  localparam int MUL_B_W  = 10;
  localparam int MUL_P_W  = MUL_A_W + 1 + MUL_B_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int MCNT_W   = $clog2(MUL_B_W);
  localparam int DIFF_W   = 7;

  localparam int STEP_SH  = 16 - POSE_FRAC_BITS;
  localparam int LINK_SH  = 8;

  localparam logic [7:0]  SERVO_LO      = 8'd43;
  localparam logic [7:0]  SERVO_HI      = 8'd150;
  localparam int          SWEEP_TOP     = 150;
  localparam logic [15:0] LINK_COEF_Q16 = 16'd63422;

  localparam logic [POSE_W-1:0] POSE_ONE   = POSE_W'(1 << POSE_FRAC_BITS);
  localparam logic [POSE_W-1:0] SWEEP_POSE = POSE_W'(SWEEP_TOP * (1 << POSE_FRAC_BITS));
  localparam logic [POSE_W-1:0] POSE_RST   = POSE_W'(100 * (1 << POSE_FRAC_BITS));
  localparam logic [POSE_W-1:0] POSE_TOP   = POSE_W'(255 * (1 << POSE_FRAC_BITS));

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
  localparam logic [MCNT_W-1:0]      MUL_LAST = MCNT_W'(MUL_B_W - 1);

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SIGHT  = 2'd1;
  localparam logic [1:0] CMD_MANUAL = 2'd2;

  localparam logic [2:0] REG_CENTER_ROW   = 3'd0;
  localparam logic [2:0] REG_UPPER_THR    = 3'd1;
  localparam logic [2:0] REG_LOWER_THR    = 3'd2;
  localparam logic [2:0] REG_GAIN         = 3'd3;
  localparam logic [2:0] REG_POSE_MIN     = 3'd4;
  localparam logic [2:0] REG_POSE_MAX     = 3'd5;
  localparam logic [2:0] REG_LOST_TICKS   = 3'd6;
  localparam logic [2:0] REG_SWEEP_PERIOD = 3'd7;

  typedef struct packed {
    logic [1:0] cmd;
    logic [9:0] image_row;
    logic [7:0] manual_position;
  } dts_in_word_t;

  typedef struct packed {
    logic [7:0]  servo_position;
    logic [14:0] link_angle;
    logic        target_lost;
  } dts_out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP_MUL,
    ST_POSE,
    ST_LINK_MUL,
    ST_DONE
  } dts_state_t;

  function automatic logic [7:0] clamp_servo(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (v > SERVO_HI) r = SERVO_HI;
    if (v < SERVO_LO) r = SERVO_LO;
    return r;
  endfunction

  function automatic logic [DIFF_W-1:0] link_diff(input logic [7:0] servo);
    logic [7:0] d;
    d = SERVO_HI - servo;
    return d[DIFF_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/deadband_tracking_servo_scan.sv
// Top level of the deadband tracking servo scan block.
// Uses dts_pkg and assert_macros.svh; holds config, pose state and a
// bit-serial shift-add multiplier shared by the pose step and link angle.
//
// One word is processed at a time. A tick that sends nothing leaves the block
// in ST_IDLE, ready for the next word. A manual command or a sweep step runs
// the link-angle product in ST_LINK_MUL, loads its result from ST_DONE and
// then returns to ST_IDLE; a sighting first runs the pose-step product in
// ST_STEP_MUL and updates the pose in ST_POSE. The bit-serial multiplier
// forms each product one multiplier bit per cycle: one product for the
// sighting pose step, one for the link angle. A finished result sits in the
// output register while the next word is accepted; a result that finds that
// register still full and stalled waits, and the input stalls with it.
`timescale 1ns / 1ps
`default_nettype none

module deadband_tracking_servo_scan (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire dts_pkg::dts_in_word_t  in_word,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output dts_pkg::dts_out_word_t      out_word,
  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [15:0]            cfg_data
);
  import dts_pkg::*;
  `include "assert_macros.svh"

  logic [9:0]  center_row_r, upper_thr_r, lower_thr_r;
  logic [15:0] gain_r;
  logic [7:0]  pose_min_r, pose_max_r;
  logic [11:0] lost_ticks_r;
  logic [5:0]  sweep_period_r;

  logic [POSE_W-1:0]      pose_r, pose_nxt;
  logic [COUNT_WIDTH-1:0] tick_count_r, tick_count_nxt;
  logic [5:0]             sweep_phase_r, sweep_phase_nxt;
  logic                   lost_flag_r, lost_flag_nxt;

  dts_state_t        state_r, state_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic [MUL_P_W-1:0] p_r, p_nxt;
  logic [MUL_A_W-1:0] mcand_r, mcand_nxt;
  logic               up_r, up_nxt, dn_r, dn_nxt;
  logic [7:0]         servo_r, servo_nxt;

  logic          out_valid_r, out_valid_nxt;
  dts_out_word_t out_word_r, out_word_nxt;

  logic accept, out_load, mul_run, tick_emit;
  logic sight_acc, link_end;

  // tick path
  logic [COUNT_WIDTH-1:0] tc_inc;
  logic                   past;
  logic [POSE_W-1:0]      base_pose, pose_dec, pose_wrap;
  logic [5:0]             base_phase, ph_inc;
  logic                   step_hit;
  logic [7:0]             tick_servo, manual_servo;

  // sighting path
  logic [9:0]              d_row;
  logic [MUL_A_W:0]        mul_sum;
  logic [MUL_P_W-1:0]      p_shift;
  logic [PROD_W:0]         step_sum;
  logic signed [EXT_W-1:0] step_e, pose_e, pose_sel, hi_e, lo_e;
  logic [POSE_W-1:0]       pose_cl;
  logic [7:0]              sight_servo;
  logic [PROD_W-1:0]       link_sum;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_word.cmd)
            CMD_SIGHT:  state_nxt = ST_STEP_MUL;
            CMD_MANUAL: state_nxt = ST_LINK_MUL;
            CMD_TICK:   state_nxt = tick_emit ? ST_LINK_MUL : ST_IDLE;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_STEP_MUL: if (cnt_r == MUL_LAST) state_nxt = ST_POSE;
      ST_POSE:     state_nxt = ST_LINK_MUL;
      ST_LINK_MUL: if (cnt_r == MUL_LAST) state_nxt = ST_DONE;
      ST_DONE:     if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- fsm outputs ----------------
  always_comb begin
    in_stall = 1'b1;
    mul_run  = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:     in_stall = 1'b0;
      ST_STEP_MUL: mul_run  = 1'b1;
      ST_LINK_MUL: mul_run  = 1'b1;
      ST_DONE:     out_load = !out_valid_r || !out_stall;
      default:     in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  // ---------------- datapath ----------------
  always_comb begin
    tc_inc     = (tick_count_r == CNT_MAX) ? tick_count_r : tick_count_r + 1'b1;
    past       = CMP_W'(tc_inc) > CMP_W'(lost_ticks_r);
    base_pose  = lost_flag_r ? pose_r : SWEEP_POSE;
    base_phase = lost_flag_r ? sweep_phase_r : 6'd0;
    ph_inc     = base_phase + 6'd1;
    step_hit   = ph_inc >= sweep_period_r;
    pose_dec   = base_pose - POSE_ONE;
    pose_wrap  = (pose_dec == '0) ? SWEEP_POSE : pose_dec;
    tick_servo = clamp_servo(pose_dec[POSE_W-1:POSE_FRAC_BITS]);
    tick_emit  = past && step_hit;
    manual_servo = clamp_servo(in_word.manual_position);

    d_row = (in_word.image_row >= center_row_r) ? in_word.image_row - center_row_r
                                                : center_row_r - in_word.image_row;

    mul_sum = p_r[MUL_P_W-1:MUL_B_W] + (p_r[0] ? {1'b0, mcand_r} : '0);
    p_shift = {1'b0, mul_sum, p_r[MUL_B_W-1:1]};

    step_sum = {1'b0, p_r[PROD_W-1:0]} + (PROD_W+1)'(1 << (STEP_SH - 1));
    step_e   = signed'(EXT_W'(step_sum >> STEP_SH));
    pose_e   = signed'(EXT_W'(pose_r));
    hi_e     = signed'(EXT_W'({pose_max_r, {POSE_FRAC_BITS{1'b0}}}));
    lo_e     = signed'(EXT_W'({pose_min_r, {POSE_FRAC_BITS{1'b0}}}));
    pose_sel = pose_e;
    if (up_r && !dn_r) pose_sel = pose_e - step_e;
    if (dn_r && !up_r) pose_sel = pose_e + step_e;
    if (pose_sel > hi_e) pose_sel = hi_e;
    if (pose_sel < lo_e) pose_sel = lo_e;
    pose_cl     = pose_sel[POSE_W-1:0];
    sight_servo = clamp_servo(pose_cl[POSE_W-1:POSE_FRAC_BITS]);

    link_sum = p_r[PROD_W-1:0] + PROD_W'(1 << (LINK_SH - 1));

    pose_nxt        = pose_r;
    tick_count_nxt  = tick_count_r;
    sweep_phase_nxt = sweep_phase_r;
    lost_flag_nxt   = lost_flag_r;
    cnt_nxt         = mul_run ? cnt_r + 1'b1 : '0;
    p_nxt           = mul_run ? p_shift : p_r;
    mcand_nxt       = mcand_r;
    up_nxt          = up_r;
    dn_nxt          = dn_r;
    servo_nxt       = servo_r;

    if (mul_run && cnt_r == MUL_LAST) cnt_nxt = '0;

    if (accept) begin
      case (in_word.cmd)
        CMD_SIGHT: begin
          tick_count_nxt = '0;
          lost_flag_nxt  = 1'b0;
          up_nxt         = in_word.image_row >= upper_thr_r;
          dn_nxt         = in_word.image_row < lower_thr_r;
          p_nxt          = {{(MUL_P_W-MUL_B_W){1'b0}}, d_row};
          mcand_nxt      = gain_r;
        end
        CMD_MANUAL: begin
          servo_nxt = manual_servo;
          p_nxt     = {{(MUL_P_W-DIFF_W){1'b0}}, link_diff(manual_servo)};
          mcand_nxt = LINK_COEF_Q16;
        end
        CMD_TICK: begin
          tick_count_nxt = tc_inc;
          if (past) begin
            lost_flag_nxt = 1'b1;
            if (step_hit) begin
              sweep_phase_nxt = 6'd0;
              pose_nxt        = pose_wrap;
              servo_nxt       = tick_servo;
              p_nxt           = {{(MUL_P_W-DIFF_W){1'b0}}, link_diff(tick_servo)};
              mcand_nxt       = LINK_COEF_Q16;
            end else begin
              sweep_phase_nxt = ph_inc;
              pose_nxt        = base_pose;
            end
          end
        end
        default: ;
      endcase
    end

    if (state_r == ST_POSE) begin
      pose_nxt  = pose_cl;
      servo_nxt = sight_servo;
      p_nxt     = {{(MUL_P_W-DIFF_W){1'b0}}, link_diff(sight_servo)};
      mcand_nxt = LINK_COEF_Q16;
    end

    out_valid_nxt = out_load || (out_valid_r && out_stall);
    out_word_nxt  = out_word_r;
    if (out_load) begin
      out_word_nxt.servo_position = servo_r;
      out_word_nxt.link_angle     = link_sum[LINK_SH+14:LINK_SH];
      out_word_nxt.target_lost    = lost_flag_r;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_row_r   <= 10'd240;
      upper_thr_r    <= 10'd250;
      lower_thr_r    <= 10'd230;
      gain_r         <= 16'd1507;
      pose_min_r     <= 8'd52;
      pose_max_r     <= 8'd148;
      lost_ticks_r   <= 12'd2000;
      sweep_period_r <= 6'd50;
      pose_r         <= POSE_RST;
      tick_count_r   <= '0;
      sweep_phase_r  <= '0;
      lost_flag_r    <= 1'b0;
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      pose_r        <= pose_nxt;
      tick_count_r  <= tick_count_nxt;
      sweep_phase_r <= sweep_phase_nxt;
      lost_flag_r   <= lost_flag_nxt;
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_ROW:   center_row_r   <= cfg_data[9:0];
          REG_UPPER_THR:    upper_thr_r    <= cfg_data[9:0];
          REG_LOWER_THR:    lower_thr_r    <= cfg_data[9:0];
          REG_GAIN:         gain_r         <= cfg_data;
          REG_POSE_MIN:     pose_min_r     <= cfg_data[7:0];
          REG_POSE_MAX:     pose_max_r     <= cfg_data[7:0];
          REG_LOST_TICKS:   lost_ticks_r   <= cfg_data[11:0];
          REG_SWEEP_PERIOD: sweep_period_r <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    mcand_r    <= mcand_nxt;
    up_r       <= up_nxt;
    dn_r       <= dn_nxt;
    servo_r    <= servo_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // ---------------- assertions ----------------
  assign sight_acc = accept && (in_word.cmd == CMD_SIGHT);
  assign link_end  = (state_r == ST_LINK_MUL) && (cnt_r == MUL_LAST);

  `DTS_ASSERT_NEXT(a_sight_to_mul, clk, rst_n, sight_acc, state_r == ST_STEP_MUL, "no step mul")
  `DTS_ASSERT_NEXT(a_link_to_done, clk, rst_n, link_end, state_r == ST_DONE, "link mul stuck")
  `DTS_ASSERT(a_pose_range, clk, rst_n, pose_r <= POSE_TOP, "stored pose out of range")

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for deadband_tracking_servo_scan.
// Depends on dts_pkg and the block RTL; predicts every servo command word in
// the testbench and checks it against the block under random idling.
`timescale 1ns / 1ps

module testbench;
  import dts_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         NUM_REGS    = 8;
  localparam int         STALL_LIMIT = 3000;
  localparam int         DRAIN_WAIT  = 30;
  localparam int         HOLD_LEN    = 300;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  dts_in_word_t  in_word = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  dts_out_word_t out_word;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_index = '0;
  logic [15:0]   cfg_data = '0;

  deadband_tracking_servo_scan DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // tracker copy: registers, pose (Q8.8 in a wide signed word), watchdog
  int  tracker_regs[NUM_REGS];
  int  next_regs[NUM_REGS];
  int  pose_q8;
  int  watch_cnt;
  int  sweep_cnt;
  bit  lost_mark;

  dts_out_word_t servo_cmd_q[$];
  int  err_count = 0;
  int  quiet_cycles = 0;
  int  rx_hold = 0;
  int  rx_gap = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic dts_out_word_t servo_word(input int pos);
    dts_out_word_t r;
    int servo, diff;
    servo = pos;
    if (servo > int'(SERVO_HI)) servo = SERVO_HI;
    if (servo < int'(SERVO_LO)) servo = SERVO_LO;
    diff = int'(SERVO_HI) - servo;
    r.servo_position = 8'(servo);
    r.link_angle = 15'((diff * int'(LINK_COEF_Q16) + (1 << (LINK_SH - 1))) >> LINK_SH);
    r.target_lost = lost_mark;
    return r;
  endfunction

  function automatic dts_out_word_t pose_word();
    return servo_word((pose_q8 < 0) ? 0 : (pose_q8 >>> POSE_FRAC_BITS));
  endfunction

  function automatic bit track_servo(input dts_in_word_t w, output dts_out_word_t r);
    int row_err, step, row, hi, lo;
    r = '0;
    row = w.image_row;
    case (w.cmd)
      CMD_SIGHT: begin
        row_err = (row >= tracker_regs[REG_CENTER_ROW]) ? row - tracker_regs[REG_CENTER_ROW]
                                                        : tracker_regs[REG_CENTER_ROW] - row;
        step = (row_err * tracker_regs[REG_GAIN] + (1 << (15 - POSE_FRAC_BITS)))
               >> (16 - POSE_FRAC_BITS);
        hi = tracker_regs[REG_POSE_MAX] << POSE_FRAC_BITS;
        lo = tracker_regs[REG_POSE_MIN] << POSE_FRAC_BITS;
        watch_cnt = 0;
        lost_mark = 1'b0;
        if (row >= tracker_regs[REG_UPPER_THR]) pose_q8 -= step;
        if (row < tracker_regs[REG_LOWER_THR]) pose_q8 += step;
        if (pose_q8 > hi) pose_q8 = hi;
        if (pose_q8 < lo) pose_q8 = lo;
        r = pose_word();
        return 1'b1;
      end
      CMD_MANUAL: begin
        r = servo_word(w.manual_position);
        return 1'b1;
      end
      CMD_TICK: begin
        if (watch_cnt < (1 << COUNT_WIDTH) - 1) watch_cnt++;
        if (watch_cnt > tracker_regs[REG_LOST_TICKS]) begin
          if (!lost_mark) begin
            lost_mark = 1'b1;
            pose_q8 = SWEEP_TOP << POSE_FRAC_BITS;
            sweep_cnt = 0;
          end
          sweep_cnt = (sweep_cnt + 1) & 63;
          if (sweep_cnt >= tracker_regs[REG_SWEEP_PERIOD]) begin
            sweep_cnt = 0;
            pose_q8 -= 1 << POSE_FRAC_BITS;
            r = pose_word();
            if (pose_q8 <= 0) pose_q8 = SWEEP_TOP << POSE_FRAC_BITS;
            return 1'b1;
          end
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_word(input dts_in_word_t w);
    dts_out_word_t r;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    if (track_servo(w, r)) servo_cmd_q.push_back(r);
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input int row, input int pos);
    dts_in_word_t w;
    w.cmd = cmd;
    w.image_row = 10'(row);
    w.manual_position = 8'(pos);
    send_word(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (servo_cmd_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic program_regs();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= 16'(next_regs[i]);
      tracker_regs[i] = next_regs[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_regs(input int lost_hi, input int period_lo, input int period_hi);
    int c, up, lw;
    c = $urandom_range(0, 1023);
    up = c + int'($urandom_range(0, 30));
    lw = c - int'($urandom_range(0, 30));
    if (up > 1023) up = 1023;
    if (lw < 0) lw = 0;
    next_regs[REG_CENTER_ROW] = c;
    next_regs[REG_UPPER_THR] = ($urandom_range(0, 5) == 0) ? lw : up;
    next_regs[REG_LOWER_THR] = ($urandom_range(0, 5) == 0) ? up : lw;
    next_regs[REG_GAIN] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 4000);
    next_regs[REG_POSE_MIN] = $urandom_range(0, 120);
    next_regs[REG_POSE_MAX] = $urandom_range(100, 255);
    next_regs[REG_LOST_TICKS] = $urandom_range(1, lost_hi);
    next_regs[REG_SWEEP_PERIOD] = $urandom_range(period_lo, period_hi);
    program_regs();
  endtask

  function automatic dts_in_word_t random_word(input int tick_pct);
    dts_in_word_t w;
    int pick, row;
    w.image_row = 10'($urandom_range(0, 1023));
    w.manual_position = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < tick_pct) begin
      w.cmd = CMD_TICK;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        w.cmd = CMD_SIGHT;
        if ($urandom_range(0, 3) != 0) begin
          row = tracker_regs[REG_CENTER_ROW] + int'($urandom_range(0, 120)) - 60;
          if (row < 0) row = 0;
          if (row > 1023) row = 1023;
          w.image_row = 10'(row);
        end
      end else if (pick < 9) begin
        w.cmd = CMD_MANUAL;
      end else begin
        w.cmd = CMD_UNUSED;
      end
    end
    return w;
  endfunction

  task automatic test_manual_clamp();
    send_cmd(CMD_MANUAL, 0, 0);
    send_cmd(CMD_MANUAL, 1023, 42);
    send_cmd(CMD_MANUAL, 0, 43);
    send_cmd(CMD_MANUAL, 0, 150);
    send_cmd(CMD_MANUAL, 0, 151);
    send_cmd(CMD_MANUAL, 0, 255);
    send_cmd(CMD_UNUSED, 1023, 255);
    wait_idle();
  endtask

  task automatic test_sighting_deadband();
    send_cmd(CMD_SIGHT, 240, 0);
    send_cmd(CMD_SIGHT, 250, 0);
    send_cmd(CMD_SIGHT, 249, 0);
    send_cmd(CMD_SIGHT, 230, 0);
    send_cmd(CMD_SIGHT, 229, 0);
    send_cmd(CMD_SIGHT, 0, 0);
    send_cmd(CMD_SIGHT, 1023, 0);
    wait_idle();
  endtask

  task automatic test_tracking_extremes();
    next_regs[REG_CENTER_ROW] = 0;
    next_regs[REG_UPPER_THR] = 0;
    next_regs[REG_LOWER_THR] = 0;
    next_regs[REG_GAIN] = 65535;
    next_regs[REG_POSE_MIN] = 0;
    next_regs[REG_POSE_MAX] = 255;
    program_regs();
    send_cmd(CMD_SIGHT, 1023, 0);
    send_cmd(CMD_SIGHT, 0, 0);
    wait_idle();
    next_regs[REG_CENTER_ROW] = 1023;
    next_regs[REG_UPPER_THR] = 1023;
    next_regs[REG_LOWER_THR] = 1023;
    program_regs();
    send_cmd(CMD_SIGHT, 0, 0);
    send_cmd(CMD_SIGHT, 1023, 0);
    wait_idle();
    // crossed thresholds: both steps apply and cancel
    next_regs[REG_CENTER_ROW] = 512;
    next_regs[REG_UPPER_THR] = 100;
    next_regs[REG_LOWER_THR] = 900;
    next_regs[REG_GAIN] = 3000;
    program_regs();
    send_cmd(CMD_SIGHT, 500, 0);
    send_cmd(CMD_SIGHT, 950, 0);
    wait_idle();
    // min above max: min wins
    next_regs[REG_POSE_MIN] = 200;
    next_regs[REG_POSE_MAX] = 60;
    program_regs();
    send_cmd(CMD_SIGHT, 20, 0);
    send_cmd(CMD_SIGHT, 1000, 0);
    wait_idle();
  endtask

  task automatic test_lost_and_sweep();
    next_regs[REG_POSE_MIN] = 52;
    next_regs[REG_POSE_MAX] = 148;
    next_regs[REG_LOST_TICKS] = 1;
    next_regs[REG_SWEEP_PERIOD] = 0;
    program_regs();
    repeat (4) send_cmd(CMD_TICK, 0, 0);
    send_cmd(CMD_MANUAL, 0, 100);
    wait_idle();
    next_regs[REG_SWEEP_PERIOD] = 2;
    program_regs();
    repeat (5) send_cmd(CMD_TICK, 1023, 255);
    wait_idle();
    // watchdog limit raised to the saturation value: sweep stops, lost mark stays
    next_regs[REG_LOST_TICKS] = 4095;
    program_regs();
    repeat (4) send_cmd(CMD_TICK, 0, 0);
    send_cmd(CMD_MANUAL, 0, 90);
    send_cmd(CMD_SIGHT, 700, 0);
    send_cmd(CMD_MANUAL, 0, 90);
    wait_idle();
  endtask

  task automatic test_output_hold();
    rx_hold = HOLD_LEN;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) send_cmd(CMD_SIGHT, $urandom_range(0, 1023), 0);
      else send_cmd(CMD_MANUAL, 0, $urandom_range(0, 255));
    end
    wait_idle();
  endtask

  task automatic test_random_mix(input int count, input int tick_pct);
    for (int i = 0; i < count; i++) send_word(random_word(tick_pct));
    wait_idle();
  endtask

  // receiver stall: long hold on request, otherwise random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else if (rx_gap > 0) begin
        out_stall <= 1'b1;
        rx_gap--;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        rx_gap = $urandom_range(0, 12);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    dts_out_word_t want;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (servo_cmd_q.size() == 0) begin
        if (err_count < 10)
          $display("unexpected word: pos %0d link %0d lost %0d",
                   out_word.servo_position, out_word.link_angle, out_word.target_lost);
        err_count++;
      end else begin
        want = servo_cmd_q.pop_front();
        if (want.servo_position !== out_word.servo_position ||
            want.link_angle !== out_word.link_angle ||
            want.target_lost !== out_word.target_lost) begin
          if (err_count < 10)
            $display("mismatch: exp pos %0d link %0d lost %0d, got pos %0d link %0d lost %0d",
                     want.servo_position, want.link_angle, want.target_lost,
                     out_word.servo_position, out_word.link_angle, out_word.target_lost);
          err_count++;
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    next_regs = '{240, 250, 230, 1507, 52, 148, 2000, 50};
    tracker_regs = next_regs;
    pose_q8 = 100 << POSE_FRAC_BITS;
    watch_cnt = 0;
    sweep_cnt = 0;
    lost_mark = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_manual_clamp();
    test_sighting_deadband();
    test_tracking_extremes();
    test_lost_and_sweep();
    test_output_hold();
    random_regs(6, 0, 4);
    test_random_mix(300, 40);
    random_regs(60, 63, 63);
    test_random_mix(300, 97);
    random_regs(4094, 0, 63);
    test_random_mix(300, 30);
    random_regs(1, 1, 1);
    test_random_mix(350, 99);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_regs(20, 0, 63);
    test_random_mix(300, 60);

    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> deadband_tracking_servo_scan.f
+incdir+hw/rtl
hw/rtl/dts_pkg.sv
hw/rtl/deadband_tracking_servo_scan.sv
test/testbench.sv
